@@ sv/caru_pkg.sv @@
package caru_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned CntW           = 5;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned NumCfg         = 6;

  localparam logic signed [31:0] PhasePerRad = 32'sd683565276;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;
  localparam logic signed [31:0] OneQ24      = 32'sd16777216;

  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_TURN  = 2'd2,
    CMD_ORBIT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PHASE,
    S_CORDIC,
    S_TRIG,
    S_MAT,
    S_COMMIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic          en;
    state_e        st;
    logic [CntW-1:0] idx;
  } wb_t;

  function automatic logic [31:0] atan_phase(input logic [CntW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ sv/camera_axis_rotation_unit.sv @@
// Camera position and look-at point unit (signed Q16.16). Commands: place copies the start
// registers, move adds amount times the look direction to both points, turn rotates the look
// direction about the axis by amount radians, orbit rotates the position about the centre.
// One command is taken at a time; in_ready_o is high only while idle. Turn and orbit run one
// CORDIC micro-rotation per cycle, then issue 24 products one per cycle (with one idle slot after
// the first 15) to a single shared 32x32 multiplier. The result is held in an output register
// until transferred.
module camera_axis_rotation_unit
  import caru_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [31:0]       amount_i,
  input  logic signed [15:0]       axis_x_i,
  input  logic signed [15:0]       axis_y_i,
  input  logic signed [15:0]       axis_z_i,
  input  logic signed [31:0]       centre_x_i,
  input  logic signed [31:0]       centre_y_i,
  input  logic signed [31:0]       centre_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output logic signed [31:0]       pos_z_o,
  output logic signed [31:0]       look_x_o,
  output logic signed [31:0]       look_y_o,
  output logic signed [31:0]       look_z_o
);

  localparam int unsigned NSteps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam logic [CntW-1:0] LastStep = CntW'(NSteps - 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  wb_t wb_q, wb_d;

  logic signed [31:0] start_q [NumCfg];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] look_q [3];

  cmd_e               cmd_q;
  logic signed [31:0] amount_q;
  logic signed [15:0] axis_q [3];
  logic signed [31:0] centre_q [3];

  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic signed [31:0] c_q, s_q, t_q;
  logic signed [31:0] v_q [3];
  logic signed [31:0] pa_q [6];
  logic signed [31:0] sa_q [3];
  logic signed [31:0] tm_q [6];
  logic [55:0]        acc_q;
  logic signed [31:0] rv_q [3];

  logic signed [31:0] opa, opb;
  logic               issue;
  logic signed [63:0] prod_d, prod_q;
  logic [55:0]        acc_sum;
  logic signed [31:0] ph;
  logic signed [31:0] ax, ay, az;
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [33:0] xn, yn;

  logic                     out_valid_q;
  logic signed [31:0]       out_pos_q [3];
  logic signed [31:0]       out_look_q [3];

  assign ax = 32'(axis_q[0]);
  assign ay = 32'(axis_q[1]);
  assign az = 32'(axis_q[2]);

  assign m00 = c_q + tm_q[0];
  assign m11 = c_q + tm_q[1];
  assign m22 = c_q + tm_q[2];
  assign m01 = tm_q[3] - sa_q[2];
  assign m02 = tm_q[4] + sa_q[1];
  assign m10 = tm_q[3] + sa_q[2];
  assign m12 = tm_q[5] - sa_q[0];
  assign m20 = tm_q[4] - sa_q[1];
  assign m21 = tm_q[5] + sa_q[0];

  assign prod_d  = opa * opb;
  assign acc_sum = acc_q + prod_q[55:0];
  assign ph      = prod_q[47:16];
  assign xn      = flip_q ? -x_q : x_q;
  assign yn      = flip_q ? -y_q : y_q;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_PLACE: state_d = S_COMMIT;
            CMD_MOVE:  state_d = S_MOVE;
            default:   state_d = S_PHASE;
          endcase
        end
      end
      S_MOVE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(3)) state_d = S_DONE;
      end
      S_PHASE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_CORDIC;
          cnt_d   = '0;
        end
      end
      S_CORDIC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) state_d = S_TRIG;
      end
      S_TRIG: begin
        cnt_d   = '0;
        state_d = S_MAT;
      end
      S_MAT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(25)) state_d = S_COMMIT;
      end
      S_COMMIT: state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier operands and handshake
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    opa   = '0;
    opb   = '0;
    issue = 1'b0;
    case (state_q)
      S_MOVE: begin
        opb = amount_q;
        case (cnt_q)
          5'd0:    begin opa = look_q[0] - pos_q[0]; issue = 1'b1; end
          5'd1:    begin opa = look_q[1] - pos_q[1]; issue = 1'b1; end
          5'd2:    begin opa = look_q[2] - pos_q[2]; issue = 1'b1; end
          default: opa = '0;
        endcase
      end
      S_PHASE: begin
        opa   = amount_q;
        opb   = PhasePerRad;
        issue = (cnt_q == '0);
      end
      S_MAT: begin
        issue = 1'b1;
        case (cnt_q)
          5'd0:  begin opa = ax;  opb = ax; end
          5'd1:  begin opa = ay;  opb = ay; end
          5'd2:  begin opa = az;  opb = az; end
          5'd3:  begin opa = ax;  opb = ay; end
          5'd4:  begin opa = ax;  opb = az; end
          5'd5:  begin opa = ay;  opb = az; end
          5'd6:  begin opa = ax;  opb = s_q; end
          5'd7:  begin opa = ay;  opb = s_q; end
          5'd8:  begin opa = az;  opb = s_q; end
          5'd9:  begin opa = t_q; opb = pa_q[0]; end
          5'd10: begin opa = t_q; opb = pa_q[1]; end
          5'd11: begin opa = t_q; opb = pa_q[2]; end
          5'd12: begin opa = t_q; opb = pa_q[3]; end
          5'd13: begin opa = t_q; opb = pa_q[4]; end
          5'd14: begin opa = t_q; opb = pa_q[5]; end
          5'd16: begin opa = m00; opb = v_q[0]; end
          5'd17: begin opa = m01; opb = v_q[1]; end
          5'd18: begin opa = m02; opb = v_q[2]; end
          5'd19: begin opa = m10; opb = v_q[0]; end
          5'd20: begin opa = m11; opb = v_q[1]; end
          5'd21: begin opa = m12; opb = v_q[2]; end
          5'd22: begin opa = m20; opb = v_q[0]; end
          5'd23: begin opa = m21; opb = v_q[1]; end
          5'd24: begin opa = m22; opb = v_q[2]; end
          default: issue = 1'b0;
        endcase
      end
      default: issue = 1'b0;
    endcase
    wb_d.en  = issue;
    wb_d.st  = state_q;
    wb_d.idx = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wb_q        <= '{en: 1'b0, st: S_IDLE, idx: '0};
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCfg - 1; i++) start_q[i] <= '0;
      start_q[5]  <= -32'sd65536;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        look_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wb_q    <= wb_d;
      if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumCfg))) start_q[cfg_idx_i] <= cfg_data_i;
      if (wb_q.en && (wb_q.st == S_MOVE)) begin
        case (wb_q.idx)
          5'd0: begin
            pos_q[0]  <= pos_q[0] + prod_q[47:16];
            look_q[0] <= look_q[0] + prod_q[47:16];
          end
          5'd1: begin
            pos_q[1]  <= pos_q[1] + prod_q[47:16];
            look_q[1] <= look_q[1] + prod_q[47:16];
          end
          5'd2: begin
            pos_q[2]  <= pos_q[2] + prod_q[47:16];
            look_q[2] <= look_q[2] + prod_q[47:16];
          end
          default: ;
        endcase
      end
      if (state_q == S_COMMIT) begin
        case (cmd_q)
          CMD_PLACE: begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i]  <= start_q[i];
              look_q[i] <= start_q[3+i];
            end
          end
          CMD_TURN: for (int i = 0; i < 3; i++) look_q[i] <= pos_q[i] + rv_q[i];
          CMD_ORBIT: for (int i = 0; i < 3; i++) pos_q[i] <= centre_q[i] + rv_q[i];
          default: ;
        endcase
      end
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_valid_i && in_ready_o) begin
      cmd_q       <= cmd_e'(cmd_i);
      amount_q    <= amount_i;
      axis_q[0]   <= axis_x_i;
      axis_q[1]   <= axis_y_i;
      axis_q[2]   <= axis_z_i;
      centre_q[0] <= centre_x_i;
      centre_q[1] <= centre_y_i;
      centre_q[2] <= centre_z_i;
    end
    if (wb_q.en && (wb_q.st == S_PHASE)) begin
      x_q <= CordicStart;
      y_q <= '0;
      if ((ph > 32'sd1073741824) || (ph < -32'sd1073741824)) begin
        flip_q <= 1'b1;
        z_q    <= {{2{~ph[31]}}, ~ph[31], ph[30:0]};
      end else begin
        flip_q <= 1'b0;
        z_q    <= 34'(ph);
      end
    end
    if (state_q == S_CORDIC) begin
      if (!z_q[33]) begin
        x_q <= x_q - (y_q >>> cnt_q);
        y_q <= y_q + (x_q >>> cnt_q);
        z_q <= z_q - signed'({2'b00, atan_phase(cnt_q)});
      end else begin
        x_q <= x_q + (y_q >>> cnt_q);
        y_q <= y_q - (x_q >>> cnt_q);
        z_q <= z_q + signed'({2'b00, atan_phase(cnt_q)});
      end
    end
    if (state_q == S_TRIG) begin
      c_q <= {{4{xn[33]}}, xn[33:6]};
      s_q <= {{4{yn[33]}}, yn[33:6]};
      t_q <= OneQ24 - {{4{xn[33]}}, xn[33:6]};
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= (cmd_q == CMD_TURN) ? (look_q[i] - pos_q[i]) : (pos_q[i] - centre_q[i]);
      end
    end
    if (wb_q.en && (wb_q.st == S_MAT)) begin
      case (wb_q.idx)
        5'd0:  pa_q[0] <= prod_q[31:0];
        5'd1:  pa_q[1] <= prod_q[31:0];
        5'd2:  pa_q[2] <= prod_q[31:0];
        5'd3:  pa_q[3] <= prod_q[31:0];
        5'd4:  pa_q[4] <= prod_q[31:0];
        5'd5:  pa_q[5] <= prod_q[31:0];
        5'd6:  sa_q[0] <= prod_q[45:14];
        5'd7:  sa_q[1] <= prod_q[45:14];
        5'd8:  sa_q[2] <= prod_q[45:14];
        5'd9:  tm_q[0] <= prod_q[59:28];
        5'd10: tm_q[1] <= prod_q[59:28];
        5'd11: tm_q[2] <= prod_q[59:28];
        5'd12: tm_q[3] <= prod_q[59:28];
        5'd13: tm_q[4] <= prod_q[59:28];
        5'd14: tm_q[5] <= prod_q[59:28];
        5'd16, 5'd19, 5'd22: acc_q <= prod_q[55:0];
        5'd17, 5'd20, 5'd23: acc_q <= acc_sum;
        5'd18: rv_q[0] <= acc_sum[55:24];
        5'd21: rv_q[1] <= acc_sum[55:24];
        5'd24: rv_q[2] <= acc_sum[55:24];
        default: ;
      endcase
    end
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      for (int i = 0; i < 3; i++) begin
        out_pos_q[i]  <= pos_q[i];
        out_look_q[i] <= look_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign pos_z_o     = out_pos_q[2];
  assign look_x_o    = out_look_q[0];
  assign look_y_o    = out_look_q[1];
  assign look_z_o    = out_look_q[2];

endmodule

@@ sv/caru_checker.sv @@
module caru_checker
  import caru_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] look_z_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a command is in progress");

  a_ready_brings_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("command finished without a result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(look_z_o))
    else $error("result dropped or changed while stalled");

endmodule

bind camera_axis_rotation_unit caru_checker u_caru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .look_z_o    (look_z_o)
);
